// File: hdl/macp_pkg.sv
// Shared types and character constants for the MAC address text parser.
`timescale 1ns / 1ps
package macp_pkg;

    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 48;
    localparam int GROUP_W = 17;
    localparam int COUNT_W = 3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
    // Offsets that map a letter onto its digit value (10..15).
    localparam logic [CHAR_W-1:0] LC_BIAS  = 8'h57;
    localparam logic [CHAR_W-1:0] UC_BIAS  = 8'h37;

    localparam logic [GROUP_W-1:0] GROUP_SAT  = 17'h10000;
    localparam logic [GROUP_W-1:0] BYTE_MAX   = 17'h000FF;
    localparam logic [GROUP_W-1:0] WORD_MAX   = 17'h0FFFF;
    localparam logic [COUNT_W-1:0] BYTE_LAST  = 3'd5;
    localparam logic [COUNT_W-1:0] WORD_LAST  = 3'd2;
    localparam logic [COUNT_W-1:0] BYTE_GROUPS = 3'd6;
    localparam logic [COUNT_W-1:0] WORD_GROUPS = 3'd3;

    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_COLON = 2'd1,
        SEP_DASH  = 2'd2,
        SEP_DOT   = 2'd3
    } sep_kind_t;

    typedef struct packed {
        logic       is_term;
        logic       is_hex;
        logic [3:0] digit;
        logic       is_sep;
        sep_kind_t  sep;
    } char_class_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } result_t;

    typedef struct packed {
        logic cleared;
    } parse_status_t;

endpackage

// File: hdl/macp_if.sv
// Valid/ready channel interfaces for characters and parse results.
`timescale 1ns / 1ps
interface macp_char_if
    import macp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface macp_result_if
    import macp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output ok, output address, input ready);
    modport sink   (input valid, input ok, input address, output ready);
endinterface

// File: hdl/macp_decode.sv
// Character classifier: terminator, hex digit with value, separator kind.
`timescale 1ns / 1ps
module macp_decode
    import macp_pkg::*;
(
    input  logic [CHAR_W-1:0] character,
    output char_class_t       char_class
);

    logic [CHAR_W-1:0] diff;

    always_comb
    begin
        char_class = '0;
        char_class.sep = SEP_NONE;
        diff = '0;
        unique case (character) inside
            CH_NUL:
            begin
                char_class.is_term = 1'b1;
            end
            [CH_DIG_0:CH_DIG_9]:
            begin
                diff = character - CH_DIG_0;
                char_class.is_hex = 1'b1;
                char_class.digit  = diff[3:0];
            end
            [CH_LC_A:CH_LC_F]:
            begin
                diff = character - LC_BIAS;
                char_class.is_hex = 1'b1;
                char_class.digit  = diff[3:0];
            end
            [CH_UC_A:CH_UC_F]:
            begin
                diff = character - UC_BIAS;
                char_class.is_hex = 1'b1;
                char_class.digit  = diff[3:0];
            end
            CH_COLON:
            begin
                char_class.is_sep = 1'b1;
                char_class.sep    = SEP_COLON;
            end
            CH_DASH:
            begin
                char_class.is_sep = 1'b1;
                char_class.sep    = SEP_DASH;
            end
            CH_DOT:
            begin
                char_class.is_sep = 1'b1;
                char_class.sep    = SEP_DOT;
            end
            default:
            begin
                char_class = '0;
            end
        endcase
    end

endmodule

// File: hdl/macp_state.sv
// Parse state registers and the per-character update, with end-of-string result.
`timescale 1ns / 1ps
module macp_state
    import macp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  char_class_t   char_class,
    output result_t       result,
    output parse_status_t status
);

    logic [GROUP_W-1:0] group_reg,  group_next;
    sep_kind_t          sep_reg,    sep_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [ADDR_W-1:0]  addr_reg,   addr_next;
    logic               err_reg,    err_next;

    logic [20:0]        acc;
    sep_kind_t          close_kind;
    logic               do_close;
    logic [COUNT_W-1:0] lane;
    logic               good;

    always_comb
    begin
        group_next = group_reg;
        sep_next   = sep_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        err_next   = err_reg;
        acc        = {group_reg, 4'h0} + {17'h0, char_class.digit};
        close_kind = SEP_NONE;
        do_close   = 1'b0;
        lane       = '0;
        good       = 1'b0;

        // Pick the event: terminator, hex digit, group close, or bad character.
        if (char_class.is_term)
        begin
            if (!err_reg)
            begin
                if (sep_reg == SEP_NONE)
                    err_next = 1'b1;
                else
                begin
                    do_close   = 1'b1;
                    close_kind = sep_reg;
                end
            end
        end
        else if (!err_reg)
        begin
            if (char_class.is_hex)
            begin
                if (group_reg >= GROUP_SAT || acc > {4'h0, GROUP_SAT})
                    group_next = GROUP_SAT;
                else
                    group_next = acc[GROUP_W-1:0];
            end
            else if (char_class.is_sep)
            begin
                do_close   = 1'b1;
                close_kind = char_class.sep;
            end
            else
                err_next = 1'b1;
        end

        // Close the current group.
        if (do_close)
        begin
            if (sep_reg != SEP_NONE && sep_reg != close_kind)
                err_next = 1'b1;
            else
            begin
                sep_next = close_kind;
                if (close_kind == SEP_DOT)
                begin
                    if (count_reg > WORD_LAST || group_reg > WORD_MAX)
                        err_next = 1'b1;
                    else
                    begin
                        lane = WORD_LAST - count_reg;
                        addr_next[lane*16 +: 16] = addr_reg[lane*16 +: 16] | group_reg[15:0];
                        count_next = count_reg + 3'd1;
                        group_next = '0;
                    end
                end
                else
                begin
                    if (count_reg > BYTE_LAST || group_reg > BYTE_MAX)
                        err_next = 1'b1;
                    else
                    begin
                        lane = BYTE_LAST - count_reg;
                        addr_next[lane*8 +: 8] = addr_reg[lane*8 +: 8] | group_reg[7:0];
                        count_next = count_reg + 3'd1;
                        group_next = '0;
                    end
                end
            end
        end

        good = !err_next && (count_next == ((sep_next == SEP_DOT) ? WORD_GROUPS : BYTE_GROUPS));
        result.ok      = good;
        result.address = good ? addr_next : '0;

        // Terminator: clear everything for the next string.
        if (char_class.is_term)
        begin
            group_next = '0;
            sep_next   = SEP_NONE;
            count_next = '0;
            addr_next  = '0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            sep_reg   <= SEP_NONE;
            count_reg <= '0;
            addr_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else if (go)
        begin
            group_reg <= group_next;
            sep_reg   <= sep_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            err_reg   <= err_next;
        end
    end

    assign status.cleared = (group_reg == '0) && (sep_reg == SEP_NONE) &&
                            (count_reg == '0) && (addr_reg == '0) && !err_reg;

endmodule

// File: hdl/mac_address_text_parser.sv
// Top level: input register, character decode, parse state update, result register.
// A terminator's result goes from the input register straight into the result register.
// Throughput: one character request per cycle; a terminator waits only while the
//   result register is full and not taken.
// Reset: rst_n (async, active low) clears valids and all parse state.
`timescale 1ns / 1ps
module mac_address_text_parser
    import macp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    macp_char_if.sink    char_in,
    macp_result_if.source result_out
);

    // Input stage.
    logic              char_valid_reg;
    logic [CHAR_W-1:0] char_reg;

    // Result stage.
    logic              res_valid_reg;
    result_t           res_reg;

    char_class_t       char_class;
    result_t           result;
    parse_status_t     status;

    logic              res_free;
    logic              go;
    logic              term_go;

    macp_decode u_decode (
        .character  (char_reg),
        .char_class (char_class)
    );

    // A held character advances unless it is a terminator and the
    // result register cannot take its result this cycle.
    assign res_free = !res_valid_reg || result_out.ready;
    assign go       = char_valid_reg && (!char_class.is_term || res_free);
    assign term_go  = go && char_class.is_term;

    assign char_in.ready = !char_valid_reg || go;

    macp_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .char_class (char_class),
        .result     (result),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_valid_reg <= 1'b0;
        else if (char_in.ready)
            char_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
            char_reg <= char_in.character;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (term_go)
            res_valid_reg <= 1'b1;
        else if (result_out.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (term_go)
            res_reg <= result;
    end

    assign result_out.valid   = res_valid_reg;
    assign result_out.ok      = res_reg.ok;
    assign result_out.address = res_reg.address;

    // A new result only ever follows a processed terminator.
    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(term_go))
        else $error("result appeared without a terminator");

    // A failed parse never shows an address.
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.ok) |-> (res_reg.address == '0))
        else $error("nonzero address on failed parse");

    // Parse state is fully cleared after a terminator.
    a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        term_go |=> status.cleared)
        else $error("parse state not cleared after terminator");

    // A terminator is never processed while the result register is blocked.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result_out.ready) |-> !term_go)
        else $error("pending result overwritten");

endmodule

// File: verif/mac_address_text_parser_tb.sv
// Self-checking testbench for the MAC address text parser: directed strings, then random ones.
`timescale 1ns / 1ps
module mac_address_text_parser_tb;
    import macp_pkg::*;

    // Run shape
    localparam int RANDOM_CHARS   = 1250;  // character requests in the random part
    localparam int HOLD_AT_RESULT = 40;    // result count at which the receiver holds off
    localparam int LONG_HOLD      = 400;   // cycles of that hold-off
    localparam int PAUSE_AT_TEXT  = 60;    // random string after which the sender drains
    localparam int DRAIN_CYCLES   = 20;    // settle time after the last result
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request accepted on either side
    localparam int MAX_WAIT       = 17;

    typedef struct {
        string   text;
        bit      fixed;  // expected result typed in below
        result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    // Directed strings; each is followed by a terminator.
    // Rows with fixed = 0 are checked against the predictor.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{"",                          1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"00:00:00:00:00:00",         1'b1, '{ok: 1'b1, address: 48'h0}},
        '{"ff-FF-ff-FF-ff-FF",         1'b1, '{ok: 1'b1, address: 48'hFFFF_FFFF_FFFF}},
        '{"ffff.FFFF.ffff",            1'b1, '{ok: 1'b1, address: 48'hFFFF_FFFF_FFFF}},
        '{"0000.0000.0000",            1'b1, '{ok: 1'b1, address: 48'h0}},
        '{"01:23:45:67:89:ab",         1'b1, '{ok: 1'b1, address: 48'h0123_4567_89AB}},
        '{"cdef.0123.4567",            1'b1, '{ok: 1'b1, address: 48'hCDEF_0123_4567}},
        '{"12:34:56:78:9a:bc:de",      1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"1.2.3.4",                   1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"12:34-56:78:9a:bc",         1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"100:00:00:00:00:00",        1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"10000.0.0",                 1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"123456789abcdef0123.0.0",   1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"12:34:56:78:9g:00",         1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"abcdef",                    1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"1:2:3:4:5",                 1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"9a:\200:bc:\377",           1'b1, '{ok: 1'b0, address: 48'h0}},
        '{"0000000000000ff:1:2:3:4:5", 1'b0, '{ok: 1'b0, address: 48'h0}},
        '{":::::",                     1'b0, '{ok: 1'b0, address: 48'h0}},
        '{"..",                        1'b0, '{ok: 1'b0, address: 48'h0}},
        '{"::::::",                    1'b0, '{ok: 1'b0, address: 48'h0}},
        '{"a-b-C-d-E-f",               1'b0, '{ok: 1'b0, address: 48'h0}},
        '{"12:34:56:78:9a:bc x!",      1'b0, '{ok: 1'b0, address: 48'h0}},
        '{"00ff.ff00.0",               1'b0, '{ok: 1'b0, address: 48'h0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    macp_char_if   char_ch ();
    macp_result_if res_ch ();

    mac_address_text_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch.sink),
        .result_out (res_ch.source)
    );

    always #2 clk = ~clk;

    // Predictor state: mirrors the parser between terminators.
    logic [GROUP_W-1:0] grp_val;
    sep_kind_t          sep_seen;
    logic [COUNT_W-1:0] grp_cnt;
    logic [ADDR_W-1:0]  addr_acc;
    bit                 err_seen;

    result_t        expected_q [$];  // parse results still owed by the block
    logic [7:0]     text_q [$];      // string being sent, terminator not included
    int             fail_count = 0;
    int             chars_sent = 0;
    int             quiet_cycles = 0;
    bit             no_idle = 1'b0;  // both sides run back to back while set

    function automatic void clear_parser();
        grp_val  = '0;
        sep_seen = SEP_NONE;
        grp_cnt  = '0;
        addr_acc = '0;
        err_seen = 1'b0;
    endfunction

    // Close the open group with separator k; the first separator fixes the form.
    function automatic void close_group(sep_kind_t k);
        if (sep_seen == SEP_NONE)
            sep_seen = k;
        if (sep_seen != k)
            err_seen = 1'b1;
        else if (k == SEP_DOT)
        begin
            if (grp_cnt > WORD_LAST || grp_val > WORD_MAX)
                err_seen = 1'b1;
            else
            begin
                addr_acc |= {32'b0, grp_val[15:0]} << (16 * int'(WORD_LAST - grp_cnt));
                grp_cnt++;
                grp_val = '0;
            end
        end
        else
        begin
            if (grp_cnt > BYTE_LAST || grp_val > BYTE_MAX)
                err_seen = 1'b1;
            else
            begin
                addr_acc |= {40'b0, grp_val[7:0]} << (8 * int'(BYTE_LAST - grp_cnt));
                grp_cnt++;
                grp_val = '0;
            end
        end
    endfunction

    // One character into the predictor; a terminator yields a parse result.
    task automatic parse_char(input logic [7:0] c, output bit emits, output result_t r);
        logic [3:0]  digit;
        bit          is_hex;
        logic [20:0] grown;
        bit          good;
        emits = 1'b0;
        r     = '0;
        digit = '0;
        if (c == CH_NUL)
        begin
            if (!err_seen)
            begin
                if (sep_seen == SEP_NONE)
                    err_seen = 1'b1;
                else
                    close_group(sep_seen);
            end
            good = !err_seen;
            if (good)
                good = (sep_seen == SEP_DOT) ? (grp_cnt == WORD_GROUPS)
                                             : (grp_cnt == BYTE_GROUPS);
            r.ok      = good;
            r.address = good ? addr_acc : '0;
            emits     = 1'b1;
            clear_parser();
        end
        else if (!err_seen)
        begin
            is_hex = 1'b1;
            if (c >= CH_DIG_0 && c <= CH_DIG_9)
                digit = 4'(c - CH_DIG_0);
            else if (c >= CH_LC_A && c <= CH_LC_F)
                digit = 4'(c - CH_LC_A + 8'd10);
            else if (c >= CH_UC_A && c <= CH_UC_F)
                digit = 4'(c - CH_UC_A + 8'd10);
            else
                is_hex = 1'b0;
            if (is_hex)
            begin
                // saturate instead of wrapping: an oversize run stays oversize
                grown = {grp_val, 4'b0} + digit;
                if (grp_val >= GROUP_SAT || grown > GROUP_SAT)
                    grp_val = GROUP_SAT;
                else
                    grp_val = grown[GROUP_W-1:0];
            end
            else
            begin
                case (c)
                    CH_COLON: close_group(SEP_COLON);
                    CH_DASH:  close_group(SEP_DASH);
                    CH_DOT:   close_group(SEP_DOT);
                    default:  err_seen = 1'b1;
                endcase
            end
        end
    endtask

    // Wait drawn per request; at least a quarter of draws are zero so back-to-back runs occur.
    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return CH_DIG_0 + 8'(v);
        if ($urandom_range(0, 1) == 1)
            return CH_UC_A + 8'(v - 10);
        return CH_LC_A + 8'(v - 10);
    endfunction

    // Offer one character request; predict on acceptance.
    task automatic send_char(input logic [7:0] c, input bit fixed, input result_t want);
        int      gap;
        bit      emits;
        result_t r;
        gap = draw_wait();
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.character <= c;
        do
            @(posedge clk);
        while (!char_ch.ready);
        chars_sent++;
        parse_char(c, emits, r);
        if (emits)
            expected_q.push_back(fixed ? want : r);
    endtask

    task automatic send_text(input bit fixed, input result_t want);
        foreach (text_q[k])
            send_char(text_q[k], 1'b0, want);
        send_char(CH_NUL, fixed, want);
    endtask

    // Random string: mostly well formed with random digits, the rest noise or broken.
    task automatic build_text();
        int         form;
        int         groups;
        int         mode;
        int         deep_group;
        int         nd;
        int         pos;
        logic [7:0] sepc;
        logic [7:0] seps [3];
        seps[0] = CH_COLON;
        seps[1] = CH_DASH;
        seps[2] = CH_DOT;
        text_q.delete();
        form   = $urandom_range(0, 2);
        sepc   = seps[form];
        groups = (form == 2) ? 3 : 6;
        mode   = $urandom_range(0, 9);
        if (mode == 0)
        begin
            // noise: any nonzero byte
            repeat ($urandom_range(0, 20))
                text_q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        deep_group = (mode == 1) ? $urandom_range(0, groups - 1) : -1;
        for (int g = 0; g < groups; g++)
        begin
            if (g > 0)
                text_q.push_back(sepc);
            if (g == deep_group)
            begin
                // long run, often led by zeros so some still fit
                nd = $urandom_range(3, 9);
                repeat (nd)
                    text_q.push_back(hex_char($urandom_range(0, 1) ? 0 : $urandom_range(0, 15)));
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    nd = 0;  // empty group reads as zero
                else
                    nd = (form == 2) ? $urandom_range(1, 4) : $urandom_range(1, 2);
                repeat (nd)
                    text_q.push_back(hex_char($urandom_range(0, 15)));
            end
        end
        if (mode == 2 && text_q.size() > 0)
        begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0: text_q[pos] = 8'($urandom_range(1, 255));
                1: text_q.delete(pos);
                2:
                begin
                    text_q.push_back(sepc);
                    text_q.push_back(hex_char($urandom_range(0, 15)));
                end
                default: text_q[pos] = seps[$urandom_range(0, 2)];
            endcase
        end
    endtask

    // Stimulus: reset, directed table, random strings, then drain.
    initial
    begin : stimulus
        int base;
        int texts;
        int done_rnd;
        rst_n             <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.character <= '0;
        res_ch.ready      <= 1'b0;
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            text_q.delete();
            for (int k = 0; k < dir_rows[i].text.len(); k++)
                text_q.push_back(dir_rows[i].text[k]);
            send_text(dir_rows[i].fixed, dir_rows[i].want);
        end

        base  = chars_sent;
        texts = 0;
        while (chars_sent - base < RANDOM_CHARS)
        begin
            done_rnd = chars_sent - base;
            // two stretches with no idling on either side
            no_idle  = (done_rnd < 200) || (done_rnd > 900 && done_rnd < 1050);
            build_text();
            send_text(1'b0, '0);
            texts++;
            if (texts == PAUSE_AT_TEXT)
            begin
                // sender goes quiet until every owed result is out
                char_ch.valid <= 1'b0;
                while (expected_q.size() != 0)
                    @(posedge clk);
            end
        end
        char_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, one long hold-off so the block backs up.
    initial
    begin : result_side
        int      stall;
        int      taken;
        result_t want;
        taken = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = (taken == HOLD_AT_RESULT) ? LONG_HOLD : draw_wait();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            taken++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, ok %0b address %012h",
                         $time, res_ch.ok, res_ch.address);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (res_ch.ok !== want.ok)
                begin
                    $display("%0t: ok mismatch, expected %0b actual %0b",
                             $time, want.ok, res_ch.ok);
                    fail_count++;
                end
                if (res_ch.address !== want.address)
                begin
                    $display("%0t: address mismatch, expected %012h actual %012h",
                             $time, want.address, res_ch.address);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no request accepted on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// File: sim.f
hdl/macp_pkg.sv
hdl/macp_if.sv
hdl/macp_decode.sv
hdl/macp_state.sv
hdl/mac_address_text_parser.sv
verif/mac_address_text_parser_tb.sv
